### rtl/stl_pkg.sv
// Package: types, codes, character constants and helpers of the source token lexer.
`default_nettype none
package stl_pkg;

  // Result queue geometry
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = $clog2(ResDepth);
  localparam int unsigned ResCntW  = $clog2(ResDepth + 1);

  // Lexer modes
  typedef enum logic [2:0] {
    ModeIdle  = 3'd0,
    ModeNum   = 3'd1,
    ModeWord  = 3'd2,
    ModeStr   = 3'd3,
    ModeEsc   = 3'd4,
    ModeOct   = 3'd5,
    ModeDot   = 3'd6,
    ModePunct = 3'd7
  } mode_e;

  // Token classes
  typedef enum logic [3:0] {
    ClsInt   = 4'd0,
    ClsFlt   = 4'd1,
    ClsExp   = 4'd2,
    ClsWord  = 4'd3,
    ClsHex   = 4'd4,
    ClsSq    = 4'd5,
    ClsDq    = 4'd6,
    ClsEof   = 4'd7,
    ClsOther = 4'd8
  } cls_e;

  // Characters
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChLpar   = 8'h28;
  localparam logic [7:0] ChRpar   = 8'h29;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChSeven  = 8'h37;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpE    = 8'h45;
  localparam logic [7:0] ChUpF    = 8'h46;
  localparam logic [7:0] ChUpZ    = 8'h5A;
  localparam logic [7:0] ChLbrk   = 8'h5B;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChRbrk   = 8'h5D;
  localparam logic [7:0] ChUscore = 8'h5F;
  localparam logic [7:0] ChLoA    = 8'h61;
  localparam logic [7:0] ChLoB    = 8'h62;
  localparam logic [7:0] ChLoE    = 8'h65;
  localparam logic [7:0] ChLoF    = 8'h66;
  localparam logic [7:0] ChLoN    = 8'h6E;
  localparam logic [7:0] ChLoR    = 8'h72;
  localparam logic [7:0] ChLoT    = 8'h74;
  localparam logic [7:0] ChLoV    = 8'h76;
  localparam logic [7:0] ChLoX    = 8'h78;
  localparam logic [7:0] ChLoZ    = 8'h7A;
  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;
  localparam logic [7:0] ChDel    = 8'h7F;

  // Decoded escape bytes
  localparam logic [7:0] ChBs = 8'h08;
  localparam logic [7:0] ChVt = 8'h0B;
  localparam logic [7:0] ChFf = 8'h0C;

  localparam logic [31:0] LineMax = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic        has_byte;
    logic [7:0]  token_byte;
    logic        token_end;
    logic [3:0]  token_class;
    logic [31:0] line_number;
  } out_item_t;

  // Results of one input transaction
  typedef struct packed {
    logic [1:0]           cnt;
    out_item_t [1:0]      r;
  } res_buf_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= ChLoA) && (c <= ChLoZ)) || ((c >= ChUpA) && (c <= ChUpZ));
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return is_digit(c) || is_alpha(c);
  endfunction

  function automatic logic is_xdigit(logic [7:0] c);
    return is_digit(c) || ((c >= ChLoA) && (c <= ChLoF)) || ((c >= ChUpA) && (c <= ChUpF));
  endfunction

  function automatic logic is_octal(logic [7:0] c);
    return (c >= ChZero) && (c <= ChSeven);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return (c > ChSpace) && (c < ChDel) && !is_alnum(c);
  endfunction

  function automatic logic is_single(logic [7:0] c);
    return (c == ChLpar) || (c == ChRpar) || (c == ChLbrace) || (c == ChRbrace) ||
           (c == ChLbrk) || (c == ChRbrk) || (c == ChSemi);
  endfunction

  // Append a token byte; drop it if both slots are taken
  function automatic res_buf_t push_byte(res_buf_t b, logic [7:0] v, cls_e cls);
    res_buf_t o;
    o = b;
    if (b.cnt < 2'd2) begin
      o.r[b.cnt[0]].has_byte    = 1'b1;
      o.r[b.cnt[0]].token_byte  = v;
      o.r[b.cnt[0]].token_end   = 1'b0;
      o.r[b.cnt[0]].token_class = cls;
      o.r[b.cnt[0]].line_number = '0;
      o.cnt                     = b.cnt + 2'd1;
    end
    return o;
  endfunction

  // Close a token: merge into a pending byte result, or append a bare end
  function automatic res_buf_t push_end(res_buf_t b, cls_e cls);
    res_buf_t   o;
    logic       last;
    o    = b;
    last = 1'(b.cnt - 2'd1);
    if ((b.cnt != 2'd0) && b.r[last].has_byte && !b.r[last].token_end) begin
      o.r[last].token_end   = 1'b1;
      o.r[last].token_class = cls;
    end else if (b.cnt < 2'd2) begin
      o.r[b.cnt[0]].has_byte    = 1'b0;
      o.r[b.cnt[0]].token_byte  = '0;
      o.r[b.cnt[0]].token_end   = 1'b1;
      o.r[b.cnt[0]].token_class = cls;
      o.r[b.cnt[0]].line_number = '0;
      o.cnt                     = b.cnt + 2'd1;
    end
    return o;
  endfunction

endpackage
`default_nettype wire

### rtl/stl_step.sv
// Lexer state registers and the per-byte next-state and result logic.
`default_nettype none
module stl_step (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire stl_pkg::in_item_t in_data_i,
  output stl_pkg::res_buf_t      res_o
);

  stl_pkg::mode_e mode_q, mode_d;
  stl_pkg::cls_e  cls_q, cls_d;
  logic           sign_q, sign_d;
  logic           olz_q, olz_d;
  logic           quote_q, quote_d;
  logic [8:0]     oct_q, oct_d;
  logic [1:0]     octn_q, octn_d;
  logic [31:0]    line_q, line_d;

  logic [7:0]        c;
  logic              eof;
  logic              run_idle;
  logic              run_str;
  logic              count_nl;
  logic              take;
  logic              keep_sign;
  logic [8:0]        oct_nx;
  logic [1:0]        octn_nx;
  logic [7:0]        quote_ch;
  stl_pkg::res_buf_t b;

  assign c   = in_data_i.ch;
  assign eof = in_data_i.end_of_input;

  always_comb begin
    mode_d    = mode_q;
    cls_d     = cls_q;
    sign_d    = sign_q;
    olz_d     = olz_q;
    quote_d   = quote_q;
    oct_d     = oct_q;
    octn_d    = octn_q;
    b         = '0;
    run_idle  = 1'b0;
    run_str   = 1'b0;
    count_nl  = 1'b0;
    take      = 1'b0;
    keep_sign = 1'b0;
    oct_nx    = {oct_q[5:0], c[2:0]};
    octn_nx   = octn_q + 2'd1;
    quote_ch  = stl_pkg::ChSquote;

    case (mode_q)
      stl_pkg::ModeNum: begin
        if (!eof) begin
          take = 1'b1;
          if (stl_pkg::is_digit(c)) begin
          end else if (stl_pkg::is_alpha(c)) begin
            if (stl_pkg::is_xdigit(c) && (cls_d == stl_pkg::ClsHex)) begin
            end else if ((c == stl_pkg::ChLoX) && (cls_d == stl_pkg::ClsInt) && olz_q) begin
              cls_d = stl_pkg::ClsHex;
            end else if (((c == stl_pkg::ChLoE) || (c == stl_pkg::ChUpE)) &&
                         ((cls_d == stl_pkg::ClsInt) || (cls_d == stl_pkg::ClsFlt))) begin
              cls_d     = stl_pkg::ClsExp;
              keep_sign = 1'b1;
            end else begin
              cls_d = stl_pkg::ClsWord;
            end
          end else if (c == stl_pkg::ChUscore) begin
            cls_d = stl_pkg::ClsWord;
          end else if ((c == stl_pkg::ChDot) && (cls_d == stl_pkg::ClsInt)) begin
            cls_d = stl_pkg::ClsFlt;
          end else if (((c == stl_pkg::ChMinus) || (c == stl_pkg::ChPlus)) && sign_q) begin
          end else begin
            take = 1'b0;
          end
        end
        if (take) begin
          olz_d  = 1'b0;
          sign_d = keep_sign;
          b      = stl_pkg::push_byte(b, c, cls_d);
        end else begin
          b        = stl_pkg::push_end(b, cls_d);
          mode_d   = stl_pkg::ModeIdle;
          run_idle = 1'b1;
        end
      end
      stl_pkg::ModeWord: begin
        if (!eof && (stl_pkg::is_alnum(c) || (c == stl_pkg::ChUscore))) begin
          b = stl_pkg::push_byte(b, c, cls_d);
        end else begin
          b        = stl_pkg::push_end(b, cls_d);
          mode_d   = stl_pkg::ModeIdle;
          run_idle = 1'b1;
        end
      end
      stl_pkg::ModeStr: begin
        run_str = 1'b1;
      end
      stl_pkg::ModeEsc: begin
        if (eof) begin
          b        = stl_pkg::push_end(b, cls_d);
          mode_d   = stl_pkg::ModeIdle;
          run_idle = 1'b1;
        end else begin
          mode_d = stl_pkg::ModeStr;
          if (stl_pkg::is_octal(c)) begin
            oct_d  = {6'd0, c[2:0]};
            octn_d = 2'd1;
            mode_d = stl_pkg::ModeOct;
          end else begin
            case (c)
              stl_pkg::ChLoB: b = stl_pkg::push_byte(b, stl_pkg::ChBs, cls_d);
              stl_pkg::ChLoF: b = stl_pkg::push_byte(b, stl_pkg::ChFf, cls_d);
              stl_pkg::ChLoN: b = stl_pkg::push_byte(b, stl_pkg::ChNl, cls_d);
              stl_pkg::ChLoR: b = stl_pkg::push_byte(b, stl_pkg::ChCr, cls_d);
              stl_pkg::ChLoT: b = stl_pkg::push_byte(b, stl_pkg::ChTab, cls_d);
              stl_pkg::ChLoV: b = stl_pkg::push_byte(b, stl_pkg::ChVt, cls_d);
              default:        b = stl_pkg::push_byte(b, c, cls_d);
            endcase
          end
        end
      end
      stl_pkg::ModeOct: begin
        if (!eof && stl_pkg::is_octal(c)) begin
          oct_d = oct_nx;
          if (octn_nx == 2'd3) begin
            b      = stl_pkg::push_byte(b, oct_nx[7:0], cls_d);
            mode_d = stl_pkg::ModeStr;
            octn_d = 2'd0;
          end else begin
            octn_d = octn_nx;
          end
        end else begin
          // flush the pending value, then treat the byte as string text
          b       = stl_pkg::push_byte(b, oct_q[7:0], cls_d);
          mode_d  = stl_pkg::ModeStr;
          octn_d  = 2'd0;
          run_str = 1'b1;
        end
      end
      stl_pkg::ModeDot: begin
        if (!eof && stl_pkg::is_digit(c)) begin
          cls_d  = stl_pkg::ClsFlt;
          sign_d = 1'b0;
          olz_d  = 1'b0;
          mode_d = stl_pkg::ModeNum;
          b      = stl_pkg::push_byte(b, c, cls_d);
        end else begin
          b        = stl_pkg::push_end(b, cls_d);
          mode_d   = stl_pkg::ModeIdle;
          run_idle = 1'b1;
        end
      end
      stl_pkg::ModePunct: begin
        if (!eof && stl_pkg::is_punct(c) && (c != stl_pkg::ChUscore) &&
            !stl_pkg::is_single(c) && (c != stl_pkg::ChDquote) &&
            (c != stl_pkg::ChSquote)) begin
          b = stl_pkg::push_byte(b, c, cls_d);
        end else begin
          b        = stl_pkg::push_end(b, cls_d);
          mode_d   = stl_pkg::ModeIdle;
          run_idle = 1'b1;
        end
      end
      default: begin
        mode_d   = stl_pkg::ModeIdle;
        run_idle = 1'b1;
      end
    endcase

    // String body: end of input, closing quote, raw newline, escape or text
    if (run_str) begin
      quote_ch = quote_d ? stl_pkg::ChDquote : stl_pkg::ChSquote;
      if (eof) begin
        b        = stl_pkg::push_end(b, cls_d);
        mode_d   = stl_pkg::ModeIdle;
        run_idle = 1'b1;
      end else if ((c == quote_ch) || (c == stl_pkg::ChNl)) begin
        b        = stl_pkg::push_end(b, cls_d);
        mode_d   = stl_pkg::ModeIdle;
        count_nl = (c == stl_pkg::ChNl);
      end else if (c == stl_pkg::ChBslash) begin
        mode_d = stl_pkg::ModeEsc;
      end else begin
        b = stl_pkg::push_byte(b, c, cls_d);
      end
    end

    // Between tokens: skip blanks, close the input, or start the next token with this byte
    if (run_idle) begin
      if (eof) begin
        cls_d = stl_pkg::ClsEof;
        b     = stl_pkg::push_end(b, stl_pkg::ClsEof);
      end else if (stl_pkg::is_space(c)) begin
        count_nl = (c == stl_pkg::ChNl);
      end else if (stl_pkg::is_digit(c)) begin
        cls_d  = stl_pkg::ClsInt;
        olz_d  = (c == stl_pkg::ChZero);
        sign_d = 1'b0;
        mode_d = stl_pkg::ModeNum;
        b      = stl_pkg::push_byte(b, c, cls_d);
      end else if (stl_pkg::is_alpha(c) || (c == stl_pkg::ChUscore)) begin
        cls_d  = stl_pkg::ClsWord;
        mode_d = stl_pkg::ModeWord;
        b      = stl_pkg::push_byte(b, c, cls_d);
      end else if ((c == stl_pkg::ChSquote) || (c == stl_pkg::ChDquote)) begin
        quote_d = (c == stl_pkg::ChDquote);
        cls_d   = quote_d ? stl_pkg::ClsDq : stl_pkg::ClsSq;
        mode_d  = stl_pkg::ModeStr;
      end else if (stl_pkg::is_single(c)) begin
        cls_d = stl_pkg::ClsOther;
        b     = stl_pkg::push_byte(b, c, cls_d);
        b     = stl_pkg::push_end(b, stl_pkg::ClsOther);
      end else begin
        cls_d  = stl_pkg::ClsOther;
        mode_d = (c == stl_pkg::ChDot) ? stl_pkg::ModeDot : stl_pkg::ModePunct;
        b      = stl_pkg::push_byte(b, c, cls_d);
      end
    end

    // Saturating line count
    line_d = (count_nl && (line_q != stl_pkg::LineMax)) ? line_q + 32'd1 : line_q;

    b.r[0].line_number = line_d;
    b.r[1].line_number = line_d;
    res_o              = b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= stl_pkg::ModeIdle;
      cls_q   <= stl_pkg::ClsInt;
      sign_q  <= 1'b0;
      olz_q   <= 1'b0;
      quote_q <= 1'b0;
      oct_q   <= '0;
      octn_q  <= '0;
      line_q  <= 32'd1;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      cls_q   <= cls_d;
      sign_q  <= sign_d;
      olz_q   <= olz_d;
      quote_q <= quote_d;
      oct_q   <= oct_d;
      octn_q  <= octn_d;
      line_q  <= line_d;
    end
  end

  // Inside a string the class is one of the two string classes
  a_str_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((mode_q == stl_pkg::ModeStr) || (mode_q == stl_pkg::ModeEsc) ||
     (mode_q == stl_pkg::ModeOct)) |->
    ((cls_q == stl_pkg::ClsSq) || (cls_q == stl_pkg::ClsDq)))
    else $error("string mode with non-string class");

  // An open octal escape holds one or two digits
  a_oct_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == stl_pkg::ModeOct) |-> ((octn_q == 2'd1) || (octn_q == 2'd2)))
    else $error("octal escape digit count out of range");

  // Line count never goes backward
  a_line_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (line_q >= $past(line_q)))
    else $error("line count decreased");

endmodule
`default_nettype wire

### rtl/stl_res_fifo.sv
// Result queue: takes up to two results per cycle while it has room for two, delivers one per transaction.
`default_nettype none
module stl_res_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_en_i,
  input  wire stl_pkg::res_buf_t  push_i,
  output logic                    room_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output stl_pkg::out_item_t      out_data_o
);

  stl_pkg::out_item_t                mem_q [stl_pkg::ResDepth];
  logic [stl_pkg::ResPtrW-1:0]       wr_q, wr_d;
  logic [stl_pkg::ResPtrW-1:0]       rd_q, rd_d;
  logic [stl_pkg::ResCntW-1:0]       cnt_q, cnt_d;
  logic [1:0]                        pc;
  logic                              pop;
  logic [stl_pkg::ResPtrW-1:0]       wr_nx;

  assign pc          = push_en_i ? push_i.cnt : 2'd0;
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_q];
  // room for a worst-case transaction of two results
  assign room_o      = (cnt_q <= stl_pkg::ResCntW'(stl_pkg::ResDepth - 2));
  assign wr_nx       = wr_q + stl_pkg::ResPtrW'(1);

  assign wr_d  = wr_q + stl_pkg::ResPtrW'(pc);
  assign rd_d  = rd_q + stl_pkg::ResPtrW'(pop);
  assign cnt_d = cnt_q + stl_pkg::ResCntW'(pc) - stl_pkg::ResCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pc != 2'd0) begin
      mem_q[wr_q] <= push_i.r[0];
    end
    if (pc == 2'd2) begin
      mem_q[wr_nx] <= push_i.r[1];
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= stl_pkg::ResCntW'(stl_pkg::ResDepth))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc != 2'd0) |-> room_o)
    else $error("result pushed without room");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (cnt_q == ($past(cnt_q) + stl_pkg::ResCntW'($past(pc)) -
                        stl_pkg::ResCntW'($past(pop)))))
    else $error("result queue count lost track");

endmodule
`default_nettype wire

### rtl/source_token_lexer_core.sv
// Top level of the source token lexer: lexer step logic and result queue.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+---------------------------
//  input   | in        | in_valid_i / in_ready_o      | in_data_i  (stl_pkg::in_item_t)
//  output  | out       | out_valid_o / out_ready_i    | out_data_o (stl_pkg::out_item_t)
//
// One input byte per cycle while in_ready_o is high: the lexer state updates in the
// cycle the byte is taken. Each byte yields zero, one or two results into a four-entry
// result queue; the output side drains one result per cycle while out_ready_i is high.
// in_ready_o drops while fewer than two queue entries are free.
// Reset clears the lexer state (line count to one) and empties the queue.
`default_nettype none
module source_token_lexer_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire stl_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output stl_pkg::out_item_t      out_data_o
);

  logic              fire;
  logic              room;
  stl_pkg::res_buf_t res;

  assign in_ready_o = room;
  assign fire       = in_valid_i && room;

  stl_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .in_data_i (in_data_i),
    .res_o     (res)
  );

  stl_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_en_i   (fire),
    .push_i      (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
